FILE: hw/rtl/mse_pkg.sv
// shared types, sizes and status codes of the merge sort engine
`default_nettype none

package mse_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } mse_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     is_last;
        logic [1:0]               status;
    } mse_out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mse_mem_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic bank;
    } mse_srt_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mse_bank_ram.sv
// generic one-write two-read memory bank with registered read data
`default_nettype none

module mse_bank_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mse_sorter.sv
// bottom-up merge sequencer sharing one compare unit, ping-ponging between two banks
`default_nettype none

module mse_sorter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [mse_pkg::CNT_W-1:0]    count,
    input  logic [mse_pkg::DATA_W-1:0]   rdata0_a,
    input  logic [mse_pkg::DATA_W-1:0]   rdata0_b,
    input  logic [mse_pkg::DATA_W-1:0]   rdata1_a,
    input  logic [mse_pkg::DATA_W-1:0]   rdata1_b,
    output mse_pkg::mse_mem_req_t        req0,
    output mse_pkg::mse_mem_req_t        req1,
    output mse_pkg::mse_srt_stat_t       stat
);
    import mse_pkg::*;

    typedef enum logic [1:0] {SR_IDLE, SR_SETUP, SR_READ, SR_MERGE} srt_state_t;

    srt_state_t        state_reg;
    logic [SUM_W-1:0]  n_reg, w_reg, lo_reg, mid_reg, hi_reg, i_reg, j_reg, k_reg;
    logic              src_reg;
    logic              done_reg;

    logic [SUM_W-1:0]  lo_w, lo_2w, mid_c, hi_c;
    logic [DATA_W-1:0] data_a, data_b, win;
    logic              take_right, merging;
    mse_mem_req_t      rd_req, wr_req;

    assign lo_w  = lo_reg + w_reg;
    assign lo_2w = lo_reg + {w_reg[SUM_W-2:0], 1'b0};
    assign mid_c = (lo_w < n_reg) ? lo_w : n_reg;
    assign hi_c  = (lo_2w < n_reg) ? lo_2w : n_reg;

    assign data_a = src_reg ? rdata1_a : rdata0_a;
    assign data_b = src_reg ? rdata1_b : rdata0_b;

    // right run wins only on strictly smaller, left run on ties
    assign take_right = (j_reg < hi_reg) &&
                        ((i_reg >= mid_reg) || ($signed(data_b) < $signed(data_a)));
    assign win     = take_right ? data_b : data_a;
    assign merging = (state_reg == SR_MERGE);

    always_comb begin
        rd_req = '{we: 1'b0, waddr: '0, wdata: '0,
                   raddr_a: i_reg[ADDR_W-1:0], raddr_b: j_reg[ADDR_W-1:0]};
        wr_req = '{we: merging, waddr: k_reg[ADDR_W-1:0], wdata: win,
                   raddr_a: i_reg[ADDR_W-1:0], raddr_b: j_reg[ADDR_W-1:0]};
        req0 = src_reg ? wr_req : rd_req;
        req1 = src_reg ? rd_req : wr_req;
    end

    assign stat = '{busy: (state_reg != SR_IDLE), done: done_reg, bank: src_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SR_IDLE;
            done_reg  <= 1'b0;
            src_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                SR_IDLE: begin
                    if (start) begin
                        n_reg     <= SUM_W'(count);
                        w_reg     <= SUM_W'(1);
                        lo_reg    <= '0;
                        src_reg   <= 1'b0;
                        state_reg <= SR_SETUP;
                    end
                end
                SR_SETUP: begin
                    if (w_reg >= n_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= SR_IDLE;
                    end else if (lo_reg >= n_reg) begin
                        // pass finished: double the run width and swap banks
                        w_reg   <= {w_reg[SUM_W-2:0], 1'b0};
                        lo_reg  <= '0;
                        src_reg <= ~src_reg;
                    end else begin
                        mid_reg   <= mid_c;
                        hi_reg    <= hi_c;
                        i_reg     <= lo_reg;
                        j_reg     <= mid_c;
                        k_reg     <= lo_reg;
                        state_reg <= SR_READ;
                    end
                end
                SR_READ: begin
                    state_reg <= SR_MERGE;
                end
                SR_MERGE: begin
                    if (take_right) begin
                        j_reg <= j_reg + SUM_W'(1);
                    end else begin
                        i_reg <= i_reg + SUM_W'(1);
                    end
                    k_reg <= k_reg + SUM_W'(1);
                    if (k_reg + SUM_W'(1) == hi_reg) begin
                        lo_reg    <= hi_reg;
                        state_reg <= SR_SETUP;
                    end else begin
                        state_reg <= SR_READ;
                    end
                end
                default: begin
                    state_reg <= SR_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/merge_sort_engine.sv
// top level of the merge sort engine: load and fetch handling, bank routing, result register
`default_nettype none

// A plain load word's result is registered and shows in the cycle after it is taken.
// The load marked last starts an ascending merge sort of the stored set of n values;
// it runs ceil(log2 n) passes over two banks in turn, each pass taking every value
// through a registered read of both run heads, then one compare and write, plus a
// setup step per run pair and per pass; sort time is set by the single shared
// comparator and the registered read ports of the banks. A fetch reads the bank
// through its registered read port, then fills the result register. The input side
// is taken again once the engine is idle and the result register is free or being emptied.
module merge_sort_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mse_pkg::mse_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mse_pkg::mse_out_t  m_data
);
    import mse_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_SORT, T_FETCH} top_state_t;

    top_state_t        state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rp_reg;
    logic              sorted_reg;
    logic              bank_reg;
    logic              m_valid_reg;
    mse_out_t          m_data_reg;
    logic [1:0]        pend_status_reg;
    logic              pend_last_reg;

    logic              accept;
    logic [CNT_W-1:0]  eff_count, new_count;
    logic              room, fetch_hit;
    logic [1:0]        load_status;
    mse_mem_req_t      host_req0, host_req1, srt_req0, srt_req1, bank_req0, bank_req1;
    mse_srt_stat_t     srt_stat;
    logic [DATA_W-1:0] rdata0_a, rdata0_b, rdata1_a, rdata1_b;

    assign s_ready = (state_reg == T_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a load after a finished sort starts a fresh set
    assign eff_count   = sorted_reg ? '0 : count_reg;
    assign room        = eff_count < CNT_W'(DEPTH);
    assign new_count   = room ? eff_count + CNT_W'(1) : eff_count;
    assign load_status = room ? ST_OK : ST_FULL;
    assign fetch_hit   = sorted_reg && (rp_reg < count_reg);

    always_comb begin
        host_req0 = '{we: accept && !s_data.op && room, waddr: eff_count[ADDR_W-1:0],
                      wdata: s_data.value, raddr_a: rp_reg[ADDR_W-1:0],
                      raddr_b: rp_reg[ADDR_W-1:0]};
        host_req1 = '{we: 1'b0, waddr: '0, wdata: '0, raddr_a: rp_reg[ADDR_W-1:0],
                      raddr_b: rp_reg[ADDR_W-1:0]};
        bank_req0 = srt_stat.busy ? srt_req0 : host_req0;
        bank_req1 = srt_stat.busy ? srt_req1 : host_req1;
    end

    mse_bank_ram #(.DATA_W(DATA_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_bank0 (
        .aclk    (aclk),
        .we      (bank_req0.we),
        .waddr   (bank_req0.waddr),
        .wdata   (bank_req0.wdata),
        .raddr_a (bank_req0.raddr_a),
        .raddr_b (bank_req0.raddr_b),
        .rdata_a (rdata0_a),
        .rdata_b (rdata0_b)
    );

    mse_bank_ram #(.DATA_W(DATA_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_bank1 (
        .aclk    (aclk),
        .we      (bank_req1.we),
        .waddr   (bank_req1.waddr),
        .wdata   (bank_req1.wdata),
        .raddr_a (bank_req1.raddr_a),
        .raddr_b (bank_req1.raddr_b),
        .rdata_a (rdata1_a),
        .rdata_b (rdata1_b)
    );

    mse_sorter u_sorter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && !s_data.op && s_data.last),
        .count    (new_count),
        .rdata0_a (rdata0_a),
        .rdata0_b (rdata0_b),
        .rdata1_a (rdata1_a),
        .rdata1_b (rdata1_b),
        .req0     (srt_req0),
        .req1     (srt_req1),
        .stat     (srt_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            rp_reg      <= '0;
            sorted_reg  <= 1'b0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        if (!s_data.op) begin
                            count_reg  <= new_count;
                            rp_reg     <= '0;
                            sorted_reg <= 1'b0;
                            if (s_data.last) begin
                                pend_status_reg <= load_status;
                                state_reg       <= T_SORT;
                            end else begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '{sorted_value: '0, is_last: 1'b0,
                                                 status: load_status};
                            end
                        end else if (fetch_hit) begin
                            pend_last_reg <= (rp_reg + CNT_W'(1) == count_reg);
                            rp_reg        <= rp_reg + CNT_W'(1);
                            state_reg     <= T_FETCH;
                        end else begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{sorted_value: '0, is_last: 1'b0,
                                             status: ST_EMPTY};
                        end
                    end
                end
                T_SORT: begin
                    if (srt_stat.done) begin
                        sorted_reg  <= 1'b1;
                        bank_reg    <= srt_stat.bank;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{sorted_value: '0, is_last: 1'b0,
                                         status: pend_status_reg};
                        state_reg   <= T_IDLE;
                    end
                end
                T_FETCH: begin
                    // sorted word sits in whichever bank the last pass wrote
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= '{sorted_value: bank_reg ? rdata1_a : rdata0_a,
                                     is_last: pend_last_reg, status: ST_OK};
                    state_reg   <= T_IDLE;
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mse_checker.sv
// port-level checker for the merge sort engine and its bind
`default_nettype none

module mse_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input mse_pkg::mse_in_t   s_data,
    input logic               m_valid,
    input logic               m_ready,
    input mse_pkg::mse_out_t  m_data
);
    import mse_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a plain load answers on the next cycle
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.op && !s_data.last |=> m_valid)
        else $error("plain load gave no result on the next cycle");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK) || (m_data.status == ST_EMPTY) ||
                    (m_data.status == ST_FULL))
        else $error("unknown status code");

    a_flag_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> (m_data.sorted_value == '0) && !m_data.is_last)
        else $error("flagged result carries a value or last mark");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: dv/tb_merge_sort_engine.sv
// self-checking testbench of the merge sort engine: directed table, random data sets, full store
module tb_merge_sort_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // the limit covers a full sort of DEPTH values, during which nothing is accepted
    localparam int WATCHDOG_LIMIT = 100_000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_WORDS   = 1900;
    localparam int FULL_SET_AT    = 150;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct {
        mse_in_t  w;
        bit       typed;
        mse_out_t res;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mse_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mse_out_t m_data;

    // sorter state as the predictor sees it
    logic signed [DATA_W-1:0] set_elems [DEPTH];
    int       set_count  = 0;
    int       fetch_ptr  = 0;
    bit       set_sorted = 1'b0;

    mse_out_t pending_results [$];
    mse_out_t oldest;
    int       mismatch_count = 0;
    int       words_sent     = 0;
    int       send_calm      = 0;
    int       idle_cycles    = 0;

    // receiver pacing
    int       press_reqs = 0;
    int       press_done = 0;
    int       hold_cnt   = 0;
    int       calm_cnt   = 0;

    merge_sort_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        if (sel < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            // narrow range so that duplicates are common
            1, 2, 3: return $signed($urandom_range(0, 15)) - 32'sd8;
            default: return $urandom();
        endcase
    endfunction

    function automatic mse_out_t predict_word(mse_in_t w);
        mse_out_t r;
        logic signed [DATA_W-1:0] key;
        int j;
        r = '{sorted_value: '0, is_last: 1'b0, status: ST_OK};
        if (w.op == OP_LOAD) begin
            if (set_sorted) begin
                set_count  = 0;
                fetch_ptr  = 0;
                set_sorted = 1'b0;
            end
            if (set_count < DEPTH) begin
                set_elems[set_count] = w.value;
                set_count++;
            end else begin
                r.status = ST_FULL;
            end
            if (w.last && set_count > 0) begin
                for (int i = 1; i < set_count; i++) begin
                    key = set_elems[i];
                    j = i;
                    while (j > 0 && set_elems[j-1] > key) begin
                        set_elems[j] = set_elems[j-1];
                        j--;
                    end
                    set_elems[j] = key;
                end
                fetch_ptr  = 0;
                set_sorted = 1'b1;
            end
        end else if (set_sorted && fetch_ptr < set_count) begin
            r.sorted_value = set_elems[fetch_ptr];
            r.is_last      = (fetch_ptr + 1 == set_count);
            fetch_ptr++;
        end else begin
            r.status = ST_EMPTY;
        end
        return r;
    endfunction

    function automatic dir_row_t row(logic op, logic signed [DATA_W-1:0] value, logic last,
                                     bit typed = 1'b0, logic signed [DATA_W-1:0] ev = '0,
                                     logic el = 1'b0, logic [1:0] es = ST_OK);
        dir_row_t r;
        r.w     = '{op: op, value: value, last: last};
        r.typed = typed;
        r.res   = '{sorted_value: ev, is_last: el, status: es};
        return r;
    endfunction

    function automatic mse_in_t make_word(logic op, logic signed [DATA_W-1:0] value, logic last);
        return '{op: op, value: value, last: last};
    endfunction

    function automatic void note_mismatch(string what, mse_out_t exp_r, mse_out_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected value %0d last %0b status %0d, got value %0d last %0b status %0d",
                     $realtime, what, exp_r.sorted_value, exp_r.is_last, exp_r.status,
                     got_r.sorted_value, got_r.is_last, got_r.status);
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic offer_word(mse_in_t w, bit typed = 1'b0, mse_out_t res = '0);
        int gap;
        mse_out_t predicted;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0)
                send_calm = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_word(w);
        pending_results.push_back(typed ? res : predicted);
        words_sent++;
    endtask

    task automatic run_set(int n);
        int fetches;
        for (int i = 0; i < n; i++)
            offer_word(make_word(OP_LOAD, rand_value(), i == n - 1));
        case ($urandom_range(0, 9))
            0: fetches = $urandom_range(0, n);
            1, 2: fetches = n + $urandom_range(1, 2);
            default: fetches = n;
        endcase
        for (int i = 0; i < fetches; i++)
            offer_word(make_word(OP_FETCH, $urandom(), 1'($urandom_range(0, 1))));
    endtask

    // receiver: random holds, calm stretches, and long holds on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (press_reqs != press_done) begin
            m_ready    <= 1'b0;
            hold_cnt   <= LONG_HOLD;
            press_done <= press_done + 1;
        end else if (hold_cnt != 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_ready <= 1'b1;
            if (calm_cnt != 0)
                calm_cnt <= calm_cnt - 1;
            else if ($urandom_range(0, 3) == 0)
                hold_cnt <= pick_gap();
            else if ($urandom_range(0, 49) == 0)
                calm_cnt <= $urandom_range(20, 100);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing expected", '0, m_data);
            end else begin
                oldest = pending_results.pop_front();
                if (m_data.sorted_value !== oldest.sorted_value)
                    note_mismatch("sorted_value differs", oldest, m_data);
                else if (m_data.is_last !== oldest.is_last)
                    note_mismatch("is_last differs", oldest, m_data);
                else if (m_data.status !== oldest.status)
                    note_mismatch("status differs", oldest, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        dir_row_t dir_rows [$];
        bit       full_done;
        int       n;
        full_done = 1'b0;

        dir_rows = {
            row(OP_FETCH, '0, 1'b0, 1'b1, '0, 1'b0, ST_EMPTY),
            row(OP_LOAD, VAL_MIN, 1'b0, 1'b1, '0, 1'b0, ST_OK),
            row(OP_LOAD, VAL_MAX, 1'b0, 1'b1, '0, 1'b0, ST_OK),
            row(OP_LOAD, '0, 1'b0),
            row(OP_LOAD, -32'sd1, 1'b0),
            row(OP_FETCH, '0, 1'b0, 1'b1, '0, 1'b0, ST_EMPTY),
            row(OP_LOAD, 32'sd1, 1'b1),
            row(OP_FETCH, '0, 1'b0, 1'b1, VAL_MIN, 1'b0, ST_OK),
            row(OP_FETCH, '0, 1'b0),
            row(OP_FETCH, '0, 1'b0),
            row(OP_FETCH, '0, 1'b0),
            row(OP_FETCH, '0, 1'b0, 1'b1, VAL_MAX, 1'b1, ST_OK),
            row(OP_FETCH, '0, 1'b0, 1'b1, '0, 1'b0, ST_EMPTY),
            row(OP_LOAD, 32'sd5, 1'b1),
            // value and last mean nothing on a fetch
            row(OP_FETCH, 32'sh5a5a_a5a5, 1'b1, 1'b1, 32'sd5, 1'b1, ST_OK),
            row(OP_LOAD, 32'sd3, 1'b0),
            row(OP_LOAD, 32'sd3, 1'b1),
            row(OP_FETCH, '0, 1'b0),
            // new set started while the last one is half fetched
            row(OP_LOAD, -32'sd7, 1'b1),
            row(OP_FETCH, '0, 1'b0, 1'b1, -32'sd7, 1'b1, ST_OK),
            row(OP_FETCH, '0, 1'b0, 1'b1, '0, 1'b0, ST_EMPTY)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        // stall the result side early so the input backs up
        press_reqs <= press_reqs + 1;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (!full_done && words_sent >= FULL_SET_AT) begin
                // fill the store, overflow it at least twice, sort on the dropped last word,
                // then fetch the lower half
                full_done = 1'b1;
                press_reqs <= press_reqs + 1;
                for (int i = 0; i < DEPTH; i++)
                    offer_word(make_word(OP_LOAD, rand_value(), 1'b0));
                offer_word(make_word(OP_LOAD, rand_value(), 1'b0));
                offer_word(make_word(OP_LOAD, rand_value(), 1'b1));
                for (int i = 0; i < DEPTH / 2; i++)
                    offer_word(make_word(OP_FETCH, $urandom(), 1'($urandom_range(0, 1))));
            end else if ($urandom_range(0, 7) == 0) begin
                // stray words: loads that may lack a closing last, early fetches
                repeat ($urandom_range(1, 4))
                    offer_word(make_word(1'($urandom_range(0, 1)), rand_value(),
                                         $urandom_range(0, 3) == 0));
            end else begin
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(50, 200);
                    1, 2, 3: n = 1;
                    default: n = $urandom_range(2, 20);
                endcase
                run_set(n);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mse_pkg.sv
hw/rtl/mse_bank_ram.sv
hw/rtl/mse_sorter.sv
hw/rtl/merge_sort_engine.sv
hw/rtl/mse_checker.sv
dv/tb_merge_sort_engine.sv
